/* rtl/erls_pkg.sv */
package erls_pkg;

  localparam int unsigned LADDER_LEVELS_DEF = 6;

  localparam int unsigned RATE_W   = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WEIGHT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEVELS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE0  = 4'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd52429;
  localparam logic [LEVEL_W-1:0]  LEVELS_RESET = 3'd6;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [LEVEL_W-1:0]  levels;
  } erls_cfg_t;

endpackage

/* rtl/erls_cfg_regs.sv */
module erls_cfg_regs import erls_pkg::*; #(
  parameter int unsigned LADDER_LEVELS = LADDER_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output erls_cfg_t             cfg_o,
  output logic [RATE_W-1:0]     rates_o [LADDER_LEVELS]
);

  logic                cfg_we;
  logic [WEIGHT_W-1:0] weight_q;
  logic [LEVEL_W-1:0]  levels_q;
  logic [RATE_W-1:0]   rates_q [LADDER_LEVELS];

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
      levels_q <= LEVELS_RESET;
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_IDX_WEIGHT) begin
        weight_q <= cfg_data_i[WEIGHT_W-1:0];
      end
      if (cfg_index_i == CFG_IDX_LEVELS) begin
        levels_q <= cfg_data_i[LEVEL_W-1:0];
      end
    end
  end

  // Writes to ladder entries above the built depth match no entry and are dropped.
  for (genvar k = 0; k < LADDER_LEVELS; k++) begin : g_rate
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rates_q[k] <= '0;
      end else if (cfg_we && (cfg_index_i == CFG_IDX_RATE0 + CFG_IDX_W'(k))) begin
        rates_q[k] <= cfg_data_i[RATE_W-1:0];
      end
    end
    assign rates_o[k] = rates_q[k];
  end

  assign cfg_o.weight = weight_q;
  assign cfg_o.levels = levels_q;

endmodule

/* rtl/erls_ewma.sv */
module erls_ewma import erls_pkg::*; (
  input  logic [RATE_W-1:0]   sample_i,
  input  logic [RATE_W-1:0]   avg_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic [RATE_W-1:0]   avg_o
);

  // w*a + (65536-w)*s equals 65536*a + (65536-w)*(s-a), so one signed
  // product and an arithmetic shift give the exact floored result.
  logic signed [RATE_W:0]            diff;
  logic signed [WEIGHT_W+1:0]        gain;
  logic signed [RATE_W+WEIGHT_W+2:0] prod;
  logic signed [RATE_W+WEIGHT_W+2:0] prod_sh;

  always_comb begin
    diff    = $signed({1'b0, sample_i}) - $signed({1'b0, avg_i});
    gain    = $signed({1'b0, 1'b1, {WEIGHT_W{1'b0}}}) - $signed({2'b00, weight_i});
    prod    = (RATE_W+WEIGHT_W+3)'(diff) * (RATE_W+WEIGHT_W+3)'(gain);
    prod_sh = prod >>> WEIGHT_W;
    if (avg_i == '0) begin
      avg_o = sample_i;
    end else begin
      // The true average always fits, so the low word of the sum is exact.
      avg_o = avg_i + prod_sh[RATE_W-1:0];
    end
  end

endmodule

/* rtl/erls_ladder.sv */
module erls_ladder import erls_pkg::*; #(
  parameter int unsigned LADDER_LEVELS = LADDER_LEVELS_DEF
) (
  input  logic [RATE_W-1:0]  avg_i,
  input  logic [LEVEL_W-1:0] levels_i,
  input  logic [RATE_W-1:0]  rates_i [LADDER_LEVELS],
  output logic [LEVEL_W-1:0] level_o,
  output logic [RATE_W-1:0]  rate_o
);

  localparam logic [LEVEL_W-1:0] LvlMax = LEVEL_W'(LADDER_LEVELS);

  logic [LEVEL_W-1:0] n_eff;

  always_comb begin
    if (levels_i == '0) begin
      n_eff = LEVEL_W'(1);
    end else if (levels_i > LvlMax) begin
      n_eff = LvlMax;
    end else begin
      n_eff = levels_i;
    end

    // Walk from the top down so the lowest exceeding entry wins.
    level_o = n_eff - LEVEL_W'(1);
    for (int i = LADDER_LEVELS - 1; i >= 0; i--) begin
      if ((LEVEL_W'(i) < n_eff) && (rates_i[i] > avg_i)) begin
        level_o = (i == 0) ? '0 : LEVEL_W'(i - 1);
      end
    end

    rate_o = '0;
    for (int i = 0; i < LADDER_LEVELS; i++) begin
      if (level_o == LEVEL_W'(i)) begin
        rate_o = rates_i[i];
      end
    end
  end

endmodule

/* rtl/ewma_rate_ladder_select_unit.sv */
// Three-register pipeline: sample register, average register, result register.
// A sample moves through the sample and average registers into the result register.
// One sample per cycle while out_stall_i is low; the average recurrence closes through avg_q alone.
// Reset clears the average to zero, empties the pipeline and restores the
// configuration registers to their default values.
module ewma_rate_ladder_select_unit import erls_pkg::*; #(
  parameter int unsigned LADDER_LEVELS = LADDER_LEVELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [RATE_W-1:0]     measured_rate_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_W-1:0]    chosen_level_o,
  output logic [RATE_W-1:0]     chosen_rate_o,
  output logic [RATE_W-1:0]     smoothed_rate_o
);

  erls_cfg_t          cfg;
  logic [RATE_W-1:0]  rates [LADDER_LEVELS];

  logic               s1_valid_q, s1_valid_d;
  logic [RATE_W-1:0]  s1_sample_q;
  logic               s2_valid_q, s2_valid_d;
  logic [RATE_W-1:0]  avg_q, avg_d;
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [RATE_W-1:0]  rate_q, rate_d;
  logic [RATE_W-1:0]  smooth_q;

  logic               s1_load, s2_load, out_load;

  erls_cfg_regs #(
    .LADDER_LEVELS(LADDER_LEVELS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .rates_o    (rates)
  );

  erls_ewma u_ewma (
    .sample_i(s1_sample_q),
    .avg_i   (avg_q),
    .weight_i(cfg.weight),
    .avg_o   (avg_d)
  );

  erls_ladder #(
    .LADDER_LEVELS(LADDER_LEVELS)
  ) u_ladder (
    .avg_i   (avg_q),
    .levels_i(cfg.levels),
    .rates_i (rates),
    .level_o (level_d),
    .rate_o  (rate_d)
  );

  // Each stage loads when it is empty or its content moves on this cycle.
  assign out_load   = s2_valid_q & (~out_valid_q | ~out_stall_i);
  assign s2_load    = s1_valid_q & (~s2_valid_q | out_load);
  assign in_stall_o = s1_valid_q & ~s2_load;
  assign s1_load    = in_valid_i & ~in_stall_o;

  assign s1_valid_d  = s1_load | (s1_valid_q & ~s2_load);
  assign s2_valid_d  = s2_load | (s2_valid_q & ~out_load);
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (s2_load) begin
        avg_q <= avg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_sample_q <= measured_rate_i;
    end
    if (out_load) begin
      level_q  <= level_d;
      rate_q   <= rate_d;
      smooth_q <= avg_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_level_o  = level_q;
  assign chosen_rate_o   = rate_q;
  assign smoothed_rate_o = smooth_q;

endmodule

/* bench/tb_ewma_rate_ladder_select_unit.sv */
`timescale 1ns / 1ps

module tb_ewma_rate_ladder_select_unit;
  import erls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SEGMENT_ITEMS = 105;
  // Indexes past the ladder registers; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO =
    CFG_IDX_W'(CFG_IDX_RATE0 + LADDER_LEVELS_DEF);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = '1;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [RATE_W-1:0]  rate;
    logic [RATE_W-1:0]  smoothed;
  } ladder_choice_t;

  class ladder_choice_tracker;
    logic [WEIGHT_W-1:0] old_weight;
    logic [LEVEL_W-1:0]  level_count;
    logic [RATE_W-1:0]   ladder [LADDER_LEVELS_DEF];
    logic [RATE_W-1:0]   smoothed;
    ladder_choice_t      choices_due [$];
    int                  errors;

    function new();
      old_weight  = WEIGHT_RESET;
      level_count = LEVELS_RESET;
      for (int k = 0; k < LADDER_LEVELS_DEF; k++) ladder[k] = '0;
      smoothed = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_IDX_WEIGHT) begin
        old_weight = data[WEIGHT_W-1:0];
      end else if (idx == CFG_IDX_LEVELS) begin
        level_count = data[LEVEL_W-1:0];
      end else if (idx >= CFG_IDX_RATE0 && idx < CFG_IDX_RATE0 + LADDER_LEVELS_DEF) begin
        ladder[idx - CFG_IDX_RATE0] = data[RATE_W-1:0];
      end
    endfunction

    function void predict_choice(logic [RATE_W-1:0] sample);
      logic [63:0]    acc;
      int unsigned    n;
      int unsigned    pick;
      bit             found;
      ladder_choice_t c;
      n = (level_count == 0) ? 1 :
          (level_count > LADDER_LEVELS_DEF) ? LADDER_LEVELS_DEF : level_count;
      // A zero average restarts the estimate from the new sample.
      if (smoothed != '0) begin
        acc = 64'(old_weight) * 64'(smoothed) + (64'd65536 - 64'(old_weight)) * 64'(sample);
        smoothed = acc[47:16];
      end else begin
        smoothed = sample;
      end
      pick  = n - 1;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!found && ladder[i] > smoothed) begin
          pick  = (i > 0) ? i - 1 : 0;
          found = 1'b1;
        end
      end
      c.level    = LEVEL_W'(pick);
      c.rate     = ladder[pick];
      c.smoothed = smoothed;
      choices_due.insert(choices_due.size(), c);
    endfunction

    function void check_choice(logic [LEVEL_W-1:0] level, logic [RATE_W-1:0] rate,
                               logic [RATE_W-1:0] avg);
      ladder_choice_t c;
      if (choices_due.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: level %0d rate %0d smoothed %0d",
                 $time, level, rate, avg);
        return;
      end
      c = choices_due.pop_front();
      if (level !== c.level) begin
        errors++;
        $display("%0t: chosen_level expected %0d actual %0d", $time, c.level, level);
      end
      if (rate !== c.rate) begin
        errors++;
        $display("%0t: chosen_rate expected %0d actual %0d", $time, c.rate, rate);
      end
      if (avg !== c.smoothed) begin
        errors++;
        $display("%0t: smoothed_rate expected %0d actual %0d", $time, c.smoothed, avg);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [RATE_W-1:0]     measured_rate_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [LEVEL_W-1:0]    chosen_level_o;
  logic [RATE_W-1:0]     chosen_rate_o;
  logic [RATE_W-1:0]     smoothed_rate_o;

  ladder_choice_tracker trk = new();

  int unsigned       send_idle_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       cycle_count = 0;
  int unsigned       sample_shift = 0;
  logic [RATE_W-1:0] ladder_plan [LADDER_LEVELS_DEF];

  ewma_rate_ladder_select_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .measured_rate_i (measured_rate_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .chosen_level_o  (chosen_level_o),
    .chosen_rate_o   (chosen_rate_o),
    .smoothed_rate_o (smoothed_rate_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // All handshakes are observed here, on values from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        trk.check_choice(chosen_level_o, chosen_rate_o, smoothed_rate_o);
      end
      if (in_valid_i && !in_stall_o) begin
        trk.predict_choice(measured_rate_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        trk.write_reg(cfg_index_i, cfg_data_i);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ewma_rate_ladder_select_unit] ERROR");
      $finish;
    end
  end

  task automatic offer_sample(input logic [RATE_W-1:0] rate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i      <= 1'b0;
      measured_rate_i <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    measured_rate_i <= rate;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Holds off new requests until every expected result has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (trk.choices_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Upper data bits carry junk to show that narrow registers keep only their width.
  task automatic load_config(input logic [WEIGHT_W-1:0] w, input logic [LEVEL_W-1:0] lv,
                             input bit stray_write);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    put_reg(CFG_IDX_WEIGHT, {junk[CFG_DATA_W-1:WEIGHT_W], w});
    put_reg(CFG_IDX_LEVELS, {junk[CFG_DATA_W-1:LEVEL_W], lv});
    for (int k = 0; k < LADDER_LEVELS_DEF; k++) begin
      put_reg(CFG_IDX_W'(CFG_IDX_RATE0 + k), ladder_plan[k]);
    end
    if (stray_write) begin
      put_reg(CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_HI, CFG_IDX_UNUSED_LO)), $urandom);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic make_ladder();
    int unsigned scale;
    int unsigned kind;
    logic [32:0] acc;
    scale = $urandom_range(31, 6);
    kind  = $urandom_range(5);
    acc   = '0;
    sample_shift = 31 - scale;
    for (int k = 0; k < LADDER_LEVELS_DEF; k++) begin
      if (kind == 0) begin
        // Unordered ladder.
        ladder_plan[k] = $urandom >> sample_shift;
      end else begin
        acc = acc + 33'($urandom >> (35 - scale));
        ladder_plan[k] = acc[32] ? '1 : acc[31:0];
      end
    end
    if (kind == 1) ladder_plan[LADDER_LEVELS_DEF-1] = '1;
  endtask

  function automatic logic [RATE_W-1:0] pick_sample();
    int unsigned k;
    k = $urandom_range(LADDER_LEVELS_DEF - 1);
    case ($urandom_range(9))
      0: pick_sample = '0;
      1: pick_sample = '1;
      2: pick_sample = ladder_plan[k] + RATE_W'($urandom_range(2)) - 1;
      3, 4: pick_sample = $urandom;
      default: pick_sample = $urandom >> sample_shift;
    endcase
  endfunction

  initial begin
    int unsigned send_tbl [4];
    int unsigned recv_tbl [4];
    logic [WEIGHT_W-1:0] w;
    logic [LEVEL_W-1:0]  lv;
    send_tbl = '{0, 72, 0, 24};
    recv_tbl = '{0, 0, 72, 24};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset ladder is all zero; a zero sample leaves the average at zero.
    offer_sample(32'd0);
    offer_sample(32'd0);
    offer_sample(32'd5000);
    offer_sample(32'hFFFF_FFFF);
    drain();

    // Zero weight: the average follows the sample, so each level edge is hit exactly.
    ladder_plan = '{32'd1000, 32'd2000, 32'd4000, 32'd8000, 32'd16000, 32'd32000};
    load_config(16'd0, 3'd6, 1'b0);
    offer_sample(32'd999);
    offer_sample(32'd1000);
    offer_sample(32'd2000);
    offer_sample(32'd31999);
    offer_sample(32'd32000);
    offer_sample(32'hFFFF_FFFF);
    offer_sample(32'd0);
    offer_sample(32'd0);
    drain();

    // Level count of zero and a ladder that is not ascending.
    ladder_plan = '{32'd5000, 32'd100, 32'hFFFF_FFFF, 32'd0, 32'd7, 32'd3};
    load_config(16'hFFFF, 3'd0, 1'b0);
    offer_sample(32'hFFFF_FFFF);
    offer_sample(32'd0);
    offer_sample(32'd12345);
    drain();

    // Level count above the ladder, plus writes to unused indexes.
    load_config(16'd1, 3'd7, 1'b1);
    @(posedge clk_i);
    put_reg(CFG_IDX_UNUSED_HI, 32'hDEAD_BEEF);
    cfg_valid_i <= 1'b0;
    offer_sample(32'd6000);
    offer_sample(32'd4);
    offer_sample(32'hFFFF_FFFE);
    offer_sample(32'd3);
    drain();

    load_config(16'd32768, 3'd1, 1'b0);
    offer_sample(32'd2);
    offer_sample(32'd5001);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_tbl[phase];
      recv_stall_pct = recv_tbl[phase];
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        make_ladder();
        case (seg)
          0: w = '0;
          1: w = '1;
          default: w = ($urandom_range(3) == 0) ? WEIGHT_RESET : WEIGHT_W'($urandom);
        endcase
        lv = (seg == 0) ? 3'd7 : (seg == 1) ? 3'd1 : LEVEL_W'($urandom_range(7));
        load_config(w, lv, ($urandom_range(3) == 0));
        for (int n = 0; n < SEGMENT_ITEMS; n++) begin
          if (seg == 1 && n == SEGMENT_ITEMS / 2) drain();
          offer_sample(pick_sample());
        end
      end
    end

    drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    if (trk.errors == 0 && trk.choices_due.size() == 0) begin
      $display("[ewma_rate_ladder_select_unit] OK");
    end else begin
      $display("[ewma_rate_ladder_select_unit] ERROR");
    end
    $finish;
  end

endmodule
